[hw/rtl/upd_pkg.sv]
// Shared types, character codes and hex helpers for the URL percent decoder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package upd_pkg;

   // Default depth of the run queue between front and back
   localparam int QueueDepth = 4;

   // Character codes
   localparam logic [7:0] CharPercent = 8'h25;
   localparam logic [7:0] CharPlus    = 8'h2B;
   localparam logic [7:0] CharSpace   = 8'h20;
   localparam logic [7:0] CharZero    = 8'h30;
   localparam logic [7:0] CharNine    = 8'h39;
   localparam logic [7:0] CharUpperA  = 8'h41;
   localparam logic [7:0] CharUpperF  = 8'h46;
   localparam logic [7:0] CharLowerA  = 8'h61;
   localparam logic [7:0] CharLowerF  = 8'h66;
   localparam logic [3:0] LetterBase  = 4'd10;

   // What the front holds between beats
   typedef enum logic [1:0] {
      HeldNone    = 2'd0,
      HeldPercent = 2'd1,
      HeldDigit   = 2'd2
   } held_type;

   // One run of decoded bytes caused by one input beat (bytes[0] goes first)
   typedef struct packed {
      logic [1:0]      count;
      logic [2:0][7:0] bytes;
      logic            string_end;
   } run_type;

   // Queue status seen by the front and back
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Classify a byte as hex digit; returns {valid, nibble}
   function automatic logic [4:0] hex_decode(logic [7:0] c);
      logic [4:0] result;
      result = 5'd0;
      if (c >= CharZero && c <= CharNine) begin
         result = {1'b1, 4'(c - CharZero)};
      end else if (c >= CharUpperA && c <= CharUpperF) begin
         result = {1'b1, 4'(c - CharUpperA) + LetterBase};
      end else if (c >= CharLowerA && c <= CharLowerF) begin
         result = {1'b1, 4'(c - CharLowerA) + LetterBase};
      end
      return result;
   endfunction

   // Map an ordinary byte: plus becomes space, all else passes
   function automatic logic [7:0] plain_map(logic [7:0] c);
      return (c == CharPlus) ? CharSpace : c;
   endfunction

endpackage

[hw/rtl/upd_front.sv]
// Front of the URL percent decoder: accepts input beats, tracks held escape
// bytes and builds one run of up to three output bytes. Depends on upd_pkg.
`timescale 1ns / 1ps

module upd_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [7:0]               req_data_byte,
   input  logic                     req_string_end,
   input  upd_pkg::queue_status_type q_status,
   output logic                     push,
   output upd_pkg::run_type         push_run
);
   import upd_pkg::*;

   held_type   held_count_ff, held_count_in;
   logic [7:0] held_digit_ff, held_digit_in;
   logic       accept;
   logic [4:0] cur_hex;
   logic [4:0] held_hex;
   logic       cur_is_hex;
   logic       both_hex;
   logic       holds_percent;
   run_type    run;

   assign req_ready     = !q_status.full;
   assign accept        = req_valid && req_ready;
   assign cur_hex       = hex_decode(req_data_byte);
   assign held_hex      = hex_decode(held_digit_ff);
   assign cur_is_hex    = cur_hex[4];
   assign both_hex      = cur_hex[4] && held_hex[4];
   assign holds_percent = (req_data_byte == CharPercent) && !req_string_end;

   // Next held state
   always_comb begin
      held_count_in = HeldNone;
      held_digit_in = held_digit_ff;
      unique case (held_count_ff)
         HeldNone: begin
            if (holds_percent) held_count_in = HeldPercent;
         end
         HeldPercent: begin
            if (cur_is_hex) begin
               held_count_in = HeldDigit;
               held_digit_in = req_data_byte;
            end else if (holds_percent) begin
               held_count_in = HeldPercent;
            end
         end
         default: begin
            if (!both_hex && holds_percent) held_count_in = HeldPercent;
         end
      endcase
      // end of string leaves nothing held
      if (req_string_end) begin
         held_count_in = HeldNone;
         held_digit_in = 8'd0;
      end
   end

   // Run of output bytes for this beat
   always_comb begin
      run            = '0;
      run.string_end = req_string_end;
      unique case (held_count_ff)
         HeldNone: begin
            if (!holds_percent) begin
               run.count    = 2'd1;
               run.bytes[0] = plain_map(req_data_byte);
            end
         end
         HeldPercent: begin
            if (cur_is_hex) begin
               if (req_string_end) begin
                  run.count    = 2'd2;
                  run.bytes[0] = CharPercent;
                  run.bytes[1] = req_data_byte;
               end
            end else begin
               run.bytes[0] = CharPercent;
               if (holds_percent) begin
                  run.count = 2'd1;
               end else begin
                  run.count    = 2'd2;
                  run.bytes[1] = plain_map(req_data_byte);
               end
            end
         end
         default: begin
            if (both_hex) begin
               run.count    = 2'd1;
               run.bytes[0] = {held_hex[3:0], cur_hex[3:0]};
            end else begin
               run.bytes[0] = CharPercent;
               run.bytes[1] = held_digit_ff;
               if (holds_percent) begin
                  run.count = 2'd2;
               end else begin
                  run.count    = 2'd3;
                  run.bytes[2] = plain_map(req_data_byte);
               end
            end
         end
      endcase
   end

   assign push     = accept && (run.count != 2'd0);
   assign push_run = run;

   // Advance held state on each accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         held_count_ff <= HeldNone;
         held_digit_ff <= 8'd0;
      end else if (accept) begin
         held_count_ff <= held_count_in;
         held_digit_ff <= held_digit_in;
      end
   end

`ifndef SYNTHESIS
   a_end_clears_state: assert property (@(posedge clock) disable iff (reset)
      (accept && req_string_end) |=> (held_count_ff == HeldNone))
      else $error("held bytes survive end of string");
   a_end_emits: assert property (@(posedge clock) disable iff (reset)
      (accept && req_string_end) |-> push)
      else $error("end of string produced no output");
`endif

endmodule

[hw/rtl/upd_queue.sv]
// Short run queue between decoder front and back.
// Depends on upd_pkg for the run type and status struct.
`timescale 1ns / 1ps

module upd_queue #(
   parameter int Depth = upd_pkg::QueueDepth
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      wr_en,
   input  upd_pkg::run_type          wr_run,
   input  logic                      rd_en,
   output upd_pkg::run_type          rd_run,
   output upd_pkg::queue_status_type status
);
   import upd_pkg::*;

   localparam int PtrW = (Depth > 2) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

   run_type         entries_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   assign status.full  = (count_ff == FullCnt);
   assign status.empty = (count_ff == '0);
   assign rd_run       = entries_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      if (rd_en) rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      if (wr_en && !rd_en) count_in = count_ff + 1'b1;
      if (rd_en && !wr_en) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store runs
   always_ff @(posedge clock) begin
      if (wr_en) entries_ff[wr_ptr_ff] <= wr_run;
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> !status.full)
      else $error("run queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> !status.empty)
      else $error("run queue underflow");
`endif

endmodule

[hw/rtl/upd_back.sv]
// Back of the URL percent decoder: walks each queued run one byte per beat
// into the registered result channel. Depends on upd_pkg.
`timescale 1ns / 1ps

module upd_back (
   input  logic                      clock,
   input  logic                      reset,
   input  upd_pkg::run_type          head_run,
   input  upd_pkg::queue_status_type q_status,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [7:0]                rsp_out_byte,
   output logic                      rsp_run_last,
   output logic                      rsp_string_last
);
   import upd_pkg::*;

   logic [1:0] pos_ff, pos_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       run_last_ff, run_last_in;
   logic       string_last_ff, string_last_in;
   logic       load;
   logic       take;

   assign load = !valid_ff || rsp_ready;
   assign take = load && !q_status.empty;

   // Select the current byte of the head run
   always_comb begin
      unique case (pos_ff)
         2'd0:    byte_in = head_run.bytes[0];
         2'd1:    byte_in = head_run.bytes[1];
         default: byte_in = head_run.bytes[2];
      endcase
      run_last_in    = (pos_ff == head_run.count - 2'd1);
      string_last_in = run_last_in && head_run.string_end;
   end

   assign pop = take && run_last_in;

   // Advance position and output valid
   always_comb begin
      pos_in = pos_ff;
      if (take) pos_in = run_last_in ? 2'd0 : pos_ff + 2'd1;
      if (take) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         valid_ff <= valid_in;
      end
   end

   // Hold payload until taken
   always_ff @(posedge clock) begin
      if (take) begin
         byte_ff        <= byte_in;
         run_last_ff    <= run_last_in;
         string_last_ff <= string_last_in;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_out_byte    = byte_ff;
   assign rsp_run_last    = run_last_ff;
   assign rsp_string_last = string_last_ff;

`ifndef SYNTHESIS
   a_string_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_string_last) |-> rsp_run_last)
      else $error("string end inside a run");
   a_pos_in_run: assert property (@(posedge clock) disable iff (reset)
      (!q_status.empty && pos_ff != 2'd0) |-> (pos_ff < head_run.count))
      else $error("run position past run length");
`endif

endmodule

[hw/rtl/url_percent_decoder.sv]
// Top level of the URL percent decoder: front, run queue and back.
// Depends on upd_pkg, upd_front, upd_queue and upd_back.
`timescale 1ns / 1ps

// Streaming URL percent decoder, one encoded byte per input beat.
// Input channel (req_): data byte plus a string_end flag on the final byte.
// Result channel (rsp_): one decoded byte per beat, with run_last on the last
// byte caused by an input beat and string_last on the final byte of a string.
// A beat may cause zero bytes (a held '%' or hex digit), one byte (plain byte,
// '+' as space, completed escape) or up to three (failed escape or flush).
// With the queue empty, an accepted beat is written into the run queue, and its
// first byte is then loaded into the output register that drives rsp_.
// Throughput: one input beat per cycle unless the queue is full, one result beat
// per cycle while rsp_ready is high; the run queue (Depth entries) absorbs a beat
// that causes three bytes, so the input keeps flowing while the back walks it out.
// Input ready drops only when the run queue is full.
// A stalled result holds in the output register while the front keeps taking
// beats into the queue.
// Reset clears the held escape state, the queue and the output valid.
module url_percent_decoder #(
   parameter int Depth = upd_pkg::QueueDepth
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_string_end,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_last,
   output logic       rsp_string_last
);
   import upd_pkg::*;

   queue_status_type q_status;
   run_type          push_run;
   run_type          head_run;
   logic             push;
   logic             pop;

   upd_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_byte  (req_data_byte),
      .req_string_end (req_string_end),
      .q_status       (q_status),
      .push           (push),
      .push_run       (push_run)
   );

   upd_queue #(
      .Depth (Depth)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (push),
      .wr_run (push_run),
      .rd_en  (pop),
      .rd_run (head_run),
      .status (q_status)
   );

   upd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_run        (head_run),
      .q_status        (q_status),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_run_last    (rsp_run_last),
      .rsp_string_last (rsp_string_last)
   );

endmodule
